// File: hw/rtl/page_lock_refcount_table_top_defines.svh
// assertion macros for the page lock refcount table
// used by page_lock_refcount_table_top; needs clk and arst_n in scope
`ifndef PAGE_LOCK_REFCOUNT_TABLE_TOP_DEFINES_SVH
`define PAGE_LOCK_REFCOUNT_TABLE_TOP_DEFINES_SVH
// same-cycle implication
`define PLRT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plrt check failed");
// next-cycle implication
`define PLRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plrt check failed");
`endif

// File: hw/rtl/plrt_pkg.sv
// shared types and constants for the page lock refcount table
// no dependencies
`timescale 1ns / 1ps
package plrt_pkg;
	localparam int DEF_TABLE_SLOTS  = 64;
	localparam int DEF_ADDRESS_BITS = 48;
	localparam int PS_MIN     = 12;
	localparam int PS_MAX     = 20;
	localparam int MAX_PAGES  = 17;
	localparam int PAGE_NUM_W = 36;
	localparam int CNT_W      = 8;
	localparam int REFUSED_W  = 17;
	localparam int LEN_W      = 16;
	localparam int PS_W       = 5;
	localparam int K_W        = 5;

	typedef enum logic [3:0] {
		ACT_EMPTY            = 4'd0,
		ACT_LOCKED           = 4'd1,
		ACT_REFUSED          = 4'd2,
		ACT_UNTRACKED        = 4'd3,
		ACT_RAISED           = 4'd4,
		ACT_UNLOCK           = 4'd5,
		ACT_LOWERED          = 4'd6,
		ACT_FORGET_UNTRACKED = 4'd7,
		ACT_KEPT_OVERFLOW    = 4'd8
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_SPAN, ST_SEARCH, ST_CLAIM
	} state_t;

	// token walking down the cell row
	typedef struct packed {
		logic             valid;
		logic             claim;
		logic             op;
		logic             done;
		logic [CNT_W-1:0] cnt;
	} tok_t;
endpackage

// File: hw/rtl/plrt_cell.sv
// one table slot: page number and reference count, passes the token on
// depends on plrt_pkg
`timescale 1ns / 1ps
module plrt_cell #(
	parameter int PG_W = 36
) (
	input  logic              clk,
	input  logic              arst_n,
	input  plrt_pkg::tok_t    tok_in,
	input  logic [PG_W-1:0]   pg_in,
	output plrt_pkg::tok_t    tok_out,
	output logic [PG_W-1:0]   pg_out
);
	import plrt_pkg::*;

	logic [PG_W-1:0]  page_q;
	logic [CNT_W-1:0] count_q;
	logic             hit;
	logic             take;
	logic [CNT_W-1:0] new_cnt;
	tok_t             tok_d;
	tok_t             tok_q;
	logic [PG_W-1:0]  pg_q;

	// live match on search, free slot on claim
	always_comb begin
		hit  = tok_in.valid && !tok_in.claim && !tok_in.done &&
			(count_q != '0) && (page_q == pg_in);
		take = tok_in.valid && tok_in.claim && !tok_in.done && (count_q == '0);
		if (tok_in.op) begin
			new_cnt = count_q - CNT_W'(1);
		end else if (count_q == '1) begin
			new_cnt = count_q;
		end else begin
			new_cnt = count_q + CNT_W'(1);
		end
	end

	// token as it leaves this cell
	always_comb begin
		tok_d      = tok_in;
		tok_d.done = tok_in.done || hit || take;
		tok_d.cnt  = hit ? new_cnt : (take ? CNT_W'(1) : tok_in.cnt);
	end

	// slot count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (hit) begin
			count_q <= new_cnt;
		end else if (take) begin
			count_q <= CNT_W'(1);
		end
	end

	// slot page
	always_ff @(posedge clk) begin
		if (take) begin
			page_q <= pg_in;
		end
	end

	// token stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		pg_q <= pg_in;
	end

	assign tok_out = tok_q;
	assign pg_out  = pg_q;
endmodule

// File: hw/rtl/page_lock_refcount_table_top.sv
// page lock refcount table: request control and the row of slot cells
// depends on plrt_pkg, plrt_cell and page_lock_refcount_table_top_defines.svh
`timescale 1ns / 1ps
`include "page_lock_refcount_table_top_defines.svh"
// Usage
//  requests: op, address, length, lock_refused taken when start is high and
//  busy is low. Results: one beat per page on page_number, action, ref_count,
//  overflow_flag and last, marked by result_valid for one cycle; last ends
//  the request. The receiver cannot stall, so results are never held.
//  A null address or zero length gives one empty beat the cycle after start.
//  Otherwise the PREP and SPAN setup states split the range, then each page
//  sends a search token down the row of TABLE_SLOTS cells, one cell per cycle;
//  a new lock needs a second claim pass. A request covers at most 17 pages.
//  One request is in work at a time; busy stays high until its last beat.
//  The page_shift register sits at byte address 0 of the APB port; the user
//  must write it only while busy is low, as the block does not enforce it.
//  Reset clears all slot counts, the overflow flag and page_shift to 12.
module page_lock_refcount_table_top #(
	parameter int TABLE_SLOTS  = plrt_pkg::DEF_TABLE_SLOTS,
	parameter int ADDRESS_BITS = plrt_pkg::DEF_ADDRESS_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic [ADDRESS_BITS-1:0]             address,
	input  logic [plrt_pkg::LEN_W-1:0]          length,
	input  logic [plrt_pkg::REFUSED_W-1:0]      lock_refused,
	output logic                                result_valid,
	output logic [plrt_pkg::PAGE_NUM_W-1:0]     page_number,
	output logic [3:0]                          action,
	output logic [plrt_pkg::CNT_W-1:0]          ref_count,
	output logic                                overflow_flag,
	output logic                                last,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import plrt_pkg::*;

	localparam int PG_W = ADDRESS_BITS - PS_MIN;

	state_t                  state_q, state_d;
	logic [PS_W-1:0]         page_shift_q;
	logic [PS_W-1:0]         ps_q;
	logic                    op_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [ADDRESS_BITS-1:0] end_q;
	logic [LEN_W-1:0]        len_q;
	logic [REFUSED_W-1:0]    ref_q;
	logic [PG_W-1:0]         pg_q;
	logic [K_W-1:0]          k_q;
	logic [K_W-1:0]          npg_q;
	logic                    ovf_q;
	logic                    inject_q;

	logic                    res_valid_q;
	logic [PAGE_NUM_W-1:0]   res_pg_q;
	act_t                    res_act_q;
	logic [CNT_W-1:0]        res_cnt_q;
	logic                    res_ovf_q;
	logic                    res_last_q;

	logic                    accept;
	logic                    is_empty;
	logic [ADDRESS_BITS:0]   end_sum;
	logic [PG_W-1:0]         first_pg;
	logic [PG_W-1:0]         last_pg;
	logic [PG_W-1:0]         span;
	logic                    cfg_wr;

	// outputs of the decision logic
	logic                    emit;
	act_t                    emit_act;
	logic [CNT_W-1:0]        emit_cnt;
	logic                    ovf_d;
	logic                    go_claim;
	logic                    fin;

	tok_t                    tok [TABLE_SLOTS+1];
	logic [PG_W-1:0]         tpg [TABLE_SLOTS+1];

	assign accept   = start && !busy;
	assign is_empty = (address == '0) || (length == '0);
	assign busy     = (state_q != ST_IDLE);
	assign fin      = (k_q + K_W'(1)) == npg_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {27'd0, page_shift_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= PS_W'(PS_MIN);
		end else if (cfg_wr) begin
			page_shift_q <= pwdata[PS_W-1:0];
		end
	end

	// range split arithmetic
	always_comb begin
		end_sum  = {1'b0, addr_q} + (ADDRESS_BITS+1)'(len_q) - (ADDRESS_BITS+1)'(1);
		first_pg = PG_W'(addr_q >> ps_q);
		last_pg  = PG_W'(end_q >> ps_q);
		span     = last_pg - first_pg;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !is_empty) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: state_d = ST_SPAN;
			ST_SPAN: state_d = ST_SEARCH;
			ST_SEARCH: begin
				if (tok[TABLE_SLOTS].valid) begin
					if (go_claim) begin
						state_d = ST_CLAIM;
					end else if (fin) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CLAIM: begin
				if (tok[TABLE_SLOTS].valid) begin
					state_d = fin ? ST_IDLE : ST_SEARCH;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// per-page decision from the returning token
	always_comb begin
		emit     = 1'b0;
		emit_act = ACT_EMPTY;
		emit_cnt = '0;
		ovf_d    = ovf_q;
		go_claim = 1'b0;
		case (state_q)
			ST_SEARCH: begin
				if (tok[TABLE_SLOTS].valid) begin
					emit = 1'b1;
					if (!op_q) begin
						if (tok[TABLE_SLOTS].done) begin
							emit_act = ACT_RAISED;
							emit_cnt = tok[TABLE_SLOTS].cnt;
						end else if (ref_q[k_q]) begin
							emit_act = ACT_REFUSED;
						end else begin
							emit     = 1'b0;
							go_claim = 1'b1;
						end
					end else if (!tok[TABLE_SLOTS].done) begin
						emit_act = ACT_FORGET_UNTRACKED;
					end else if (tok[TABLE_SLOTS].cnt != '0) begin
						emit_act = ACT_LOWERED;
						emit_cnt = tok[TABLE_SLOTS].cnt;
					end else if (ovf_q) begin
						emit_act = ACT_KEPT_OVERFLOW;
					end else begin
						emit_act = ACT_UNLOCK;
					end
				end
			end
			ST_CLAIM: begin
				if (tok[TABLE_SLOTS].valid) begin
					emit = 1'b1;
					if (tok[TABLE_SLOTS].done) begin
						emit_act = ACT_LOCKED;
						emit_cnt = CNT_W'(1);
					end else begin
						emit_act = ACT_UNTRACKED;
						ovf_d    = 1'b1;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ovf_q       <= 1'b0;
			inject_q    <= 1'b0;
			res_valid_q <= 1'b0;
			k_q         <= '0;
			npg_q       <= '0;
		end else begin
			state_q     <= state_d;
			ovf_q       <= ovf_d;
			inject_q    <= (state_q == ST_SPAN) || go_claim ||
				(state_q == ST_CLAIM && tok[TABLE_SLOTS].valid && !fin) ||
				(state_q == ST_SEARCH && emit && !fin);
			res_valid_q <= emit || (accept && is_empty);
			if (state_q == ST_SPAN) begin
				k_q   <= '0;
				npg_q <= (span >= PG_W'(MAX_PAGES - 1)) ? K_W'(MAX_PAGES)
					: K_W'(span) + K_W'(1);
			end else if (emit) begin
				k_q <= k_q + K_W'(1);
			end
		end
	end

	// request payload and page walk
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			addr_q <= address;
			len_q  <= length;
			ref_q  <= lock_refused;
		end
		if (state_q == ST_PREP) begin
			end_q <= end_sum[ADDRESS_BITS] ? '1 : end_sum[ADDRESS_BITS-1:0];
		end
		if (state_q == ST_IDLE) begin
			if (page_shift_q < PS_W'(PS_MIN)) begin
				ps_q <= PS_W'(PS_MIN);
			end else if (page_shift_q > PS_W'(PS_MAX)) begin
				ps_q <= PS_W'(PS_MAX);
			end else begin
				ps_q <= page_shift_q;
			end
		end
		if (state_q == ST_SPAN) begin
			pg_q <= first_pg;
		end else if (emit) begin
			pg_q <= pg_q + PG_W'(1);
		end
		// result beat
		if (accept && is_empty) begin
			res_pg_q   <= '0;
			res_act_q  <= ACT_EMPTY;
			res_cnt_q  <= '0;
			res_ovf_q  <= ovf_q;
			res_last_q <= 1'b1;
		end else if (emit) begin
			res_pg_q   <= PAGE_NUM_W'(pg_q);
			res_act_q  <= emit_act;
			res_cnt_q  <= emit_cnt;
			res_ovf_q  <= ovf_d;
			res_last_q <= fin;
		end
	end

	// token into the first cell
	always_comb begin
		tok[0].valid = inject_q;
		tok[0].claim = (state_q == ST_CLAIM);
		tok[0].op    = op_q;
		tok[0].done  = 1'b0;
		tok[0].cnt   = '0;
		tpg[0]       = pg_q;
	end

	// row of slot cells
	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		plrt_cell #(.PG_W(PG_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.pg_in   (tpg[i]),
			.tok_out (tok[i+1]),
			.pg_out  (tpg[i+1])
		);
	end

	assign result_valid  = res_valid_q;
	assign page_number   = res_pg_q;
	assign action        = res_act_q;
	assign ref_count     = res_cnt_q;
	assign overflow_flag = res_ovf_q;
	assign last          = res_last_q;

	// checks
	`PLRT_ASSERT_NOW(a_tok_ret_busy, tok[TABLE_SLOTS].valid,
		state_q == ST_SEARCH || state_q == ST_CLAIM)
	`PLRT_ASSERT_NOW(a_claim_keep, state_q == ST_CLAIM, !op_q)
	`PLRT_ASSERT_NOW(a_empty_last, result_valid && action == ACT_EMPTY, last)
	`PLRT_ASSERT_NEXT(a_ovf_sticky, ovf_q, ovf_q)
endmodule

// File: tb/page_lock_refcount_table_top_tb.sv
// self-checking testbench for the page lock refcount table
// depends on plrt_pkg and page_lock_refcount_table_top
`timescale 1ns / 1ps
module page_lock_refcount_table_top_tb;
	import plrt_pkg::*;

	localparam int SLOTS = DEF_TABLE_SLOTS;
	localparam int ABITS = DEF_ADDRESS_BITS;
	localparam logic [63:0] ADDR_TOP = (64'd1 << ABITS) - 64'd1;
	localparam logic [2:0] REG_PAGE_SHIFT = 3'd0;

	typedef struct {
		logic [PAGE_NUM_W-1:0] page;
		act_t                  act;
		logic [CNT_W-1:0]      cnt;
		logic                  ovf;
		logic                  fin;
	} page_beat_t;

	typedef struct {
		logic                  op;
		logic [63:0]           addr;
		logic [LEN_W-1:0]      len;
		logic [REFUSED_W-1:0]  refd;
		bit                    typed;
		act_t                  act;
		logic [PAGE_NUM_W-1:0] page;
		logic [CNT_W-1:0]      cnt;
	} req_row_t;

	logic clk, arst_n, start, busy, op;
	logic [ABITS-1:0] address;
	logic [LEN_W-1:0] length;
	logic [REFUSED_W-1:0] lock_refused;
	logic result_valid, overflow_flag, last;
	logic [PAGE_NUM_W-1:0] page_number;
	logic [3:0] action;
	logic [CNT_W-1:0] ref_count;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	// mirror of the lock table
	logic [63:0] mir_page [SLOTS];
	logic [CNT_W-1:0] mir_count [SLOTS];
	logic mir_ovf;
	logic [PS_W-1:0] mir_shift;

	page_beat_t pending_beats[$];
	int errors = 0;
	int burst_left = 0;
	logic [63:0] pool [8];

	page_lock_refcount_table_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.address(address), .length(length), .lock_refused(lock_refused),
		.result_valid(result_valid), .page_number(page_number), .action(action),
		.ref_count(ref_count), .overflow_flag(overflow_flag), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("page_lock_refcount_table_top_tb: FAIL");
		$finish;
	end

	// walk the pages of one request, update the mirror and, if keep_beats, queue the beats it should give
	task automatic walk_pages(input logic rop, input logic [63:0] raddr,
			input logic [LEN_W-1:0] rlen, input logic [REFUSED_W-1:0] rrefd,
			input bit keep_beats);
		int ps, npg, hit, fre;
		logic [63:0] a, e, first, pg;
		page_beat_t b;
		a = raddr & ADDR_TOP;
		if (a == 0 || rlen == 0) begin
			b = '{page: '0, act: ACT_EMPTY, cnt: '0, ovf: mir_ovf, fin: 1'b1};
			if (keep_beats) pending_beats.push_back(b);
			return;
		end
		ps = mir_shift;
		if (ps < PS_MIN) ps = PS_MIN;
		if (ps > PS_MAX) ps = PS_MAX;
		e = a + rlen - 64'd1;
		if (e > ADDR_TOP) e = ADDR_TOP;
		first = a >> ps;
		npg = int'((e >> ps) - first) + 1;
		if (npg > MAX_PAGES) npg = MAX_PAGES;
		for (int k = 0; k < npg; k++) begin
			pg = first + k;
			hit = -1;
			fre = -1;
			for (int s = SLOTS - 1; s >= 0; s--) begin
				if (mir_count[s] != 0 && mir_page[s] == pg) hit = s;
				if (mir_count[s] == 0) fre = s;
			end
			b.page = pg[PAGE_NUM_W-1:0];
			b.cnt = '0;
			b.fin = (k == npg - 1);
			if (rop == 1'b0) begin
				if (hit >= 0) begin
					if (mir_count[hit] != 8'hFF) mir_count[hit]++;
					b.act = ACT_RAISED;
					b.cnt = mir_count[hit];
				end else if (rrefd[k]) begin
					b.act = ACT_REFUSED;
				end else if (fre >= 0) begin
					mir_page[fre] = pg;
					mir_count[fre] = 8'd1;
					b.act = ACT_LOCKED;
					b.cnt = 8'd1;
				end else begin
					mir_ovf = 1'b1;
					b.act = ACT_UNTRACKED;
				end
			end else begin
				if (hit < 0) begin
					b.act = ACT_FORGET_UNTRACKED;
				end else begin
					mir_count[hit]--;
					b.cnt = mir_count[hit];
					if (mir_count[hit] != 0) b.act = ACT_LOWERED;
					else if (mir_ovf) b.act = ACT_KEPT_OVERFLOW;
					else b.act = ACT_UNLOCK;
				end
			end
			b.ovf = mir_ovf;
			if (keep_beats) pending_beats.push_back(b);
		end
	endtask

	// present one request and wait for it to be taken
	task automatic send_req(input req_row_t r);
		page_beat_t b;
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 30)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		start = 1'b1;
		op = r.op;
		address = r.addr[ABITS-1:0];
		length = r.len;
		lock_refused = r.refd;
		do @(posedge clk); while (busy);
		walk_pages(r.op, r.addr, r.len, r.refd, !r.typed);
		if (r.typed) begin
			b = '{page: r.page, act: r.act, cnt: r.cnt, ovf: mir_ovf, fin: 1'b1};
			pending_beats.push_back(b);
		end
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_beats.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, block idle
	task automatic write_shift(input logic [31:0] v);
		wait_drained();
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = REG_PAGE_SHIFT;
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		mir_shift = v[PS_W-1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic req_row_t rand_req(input bit use_pool);
		req_row_t r;
		int sel;
		r.typed = 0;
		r.act = ACT_EMPTY;
		r.page = '0;
		r.cnt = '0;
		r.op = $urandom_range(0, 1);
		r.refd = ($urandom_range(0, 3) == 0) ? REFUSED_W'($urandom) : '0;
		sel = $urandom_range(0, 99);
		if (use_pool && sel < 70)
			r.addr = pool[$urandom_range(0, 7)] + $urandom_range(0, 16'hFFFF);
		else if (sel < 85)
			r.addr = {$urandom, $urandom};
		else if (sel < 92)
			r.addr = ADDR_TOP - $urandom_range(0, 20000);
		else if (sel < 96)
			r.addr = 64'd0;
		else
			r.addr = {$urandom, $urandom};
		r.addr &= ADDR_TOP;
		sel = $urandom_range(0, 99);
		if (sel < 5) r.len = '0;
		else if (sel < 65) r.len = $urandom_range(1, 8192);
		else r.len = $urandom_range(1, 16'hFFFF);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		page_beat_t b;
		if (arst_n && result_valid) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat page %h action %0d", $time, page_number, action);
				errors++;
			end else begin
				b = pending_beats.pop_front();
				if (page_number !== b.page) begin
					$display("%0t: page_number exp %h got %h", $time, b.page, page_number);
					errors++;
				end
				if (action !== 4'(b.act)) begin
					$display("%0t: action exp %0d got %0d", $time, b.act, action);
					errors++;
				end
				if (ref_count !== b.cnt) begin
					$display("%0t: ref_count exp %0d got %0d", $time, b.cnt, ref_count);
					errors++;
				end
				if (overflow_flag !== b.ovf) begin
					$display("%0t: overflow_flag exp %b got %b", $time, b.ovf, overflow_flag);
					errors++;
				end
				if (last !== b.fin) begin
					$display("%0t: last exp %b got %b", $time, b.fin, last);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		req_row_t rows [14];
		req_row_t r;
		arst_n = 1'b0;
		start = 1'b0;
		op = 1'b0;
		address = '0;
		length = '0;
		lock_refused = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int s = 0; s < SLOTS; s++) begin
			mir_page[s] = '0;
			mir_count[s] = '0;
		end
		mir_ovf = 1'b0;
		mir_shift = PS_W'(PS_MIN);
		foreach (pool[i]) pool[i] = {$urandom, $urandom} & ADDR_TOP;

		// directed rows: null, empty, lock, refusal, raise, lower, unlock, span edges
		rows[0]  = '{0, 64'h0,            16'd100,  17'h0,     1, ACT_EMPTY,   36'h0, 8'd0};
		rows[1]  = '{0, 64'h5000,         16'd0,    17'h1FFFF, 1, ACT_EMPTY,   36'h0, 8'd0};
		rows[2]  = '{0, 64'h1000,         16'd1,    17'h0,     1, ACT_LOCKED,  36'h1, 8'd1};
		rows[3]  = '{0, 64'h2000,         16'd1,    17'h1,     1, ACT_REFUSED, 36'h2, 8'd0};
		rows[4]  = '{0, 64'h1000,         16'h3000, 17'h0,     0, ACT_EMPTY,   36'h0, 8'd0};
		rows[5]  = '{1, 64'h1FFF,         16'd1,    17'h0,     0, ACT_EMPTY,   36'h0, 8'd0};
		rows[6]  = '{1, 64'h1000,         16'd1,    17'h0,     0, ACT_EMPTY,   36'h0, 8'd0};
		rows[7]  = '{1, 64'h9000,         16'd1,    17'h0,     0, ACT_EMPTY,   36'h0, 8'd0};
		rows[8]  = '{0, ADDR_TOP,         16'hFFFF, 17'h0,     0, ACT_EMPTY,   36'h0, 8'd0};
		rows[9]  = '{0, ADDR_TOP - 64'h1FFF, 16'hFFFF, 17'h0,  0, ACT_EMPTY,   36'h0, 8'd0};
		rows[10] = '{0, 64'h100FFF,       16'hFFFF, 17'h0AAAA, 0, ACT_EMPTY,   36'h0, 8'd0};
		rows[11] = '{0, 64'h100FFF,       16'hFFFF, 17'h15555, 0, ACT_EMPTY,   36'h0, 8'd0};
		rows[12] = '{1, 64'h100FFF,       16'hFFFF, 17'h0,     0, ACT_EMPTY,   36'h0, 8'd0};
		rows[13] = '{1, 64'h100FFF,       16'hFFFF, 17'h1FFFF, 0, ACT_EMPTY,   36'h0, 8'd0};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (rows[i]) send_req(rows[i]);

		// widest pages, then out-of-range shifts on both sides, then shifts 16 and 12
		write_shift(32'd20);
		for (int i = 0; i < 25; i++) send_req(rand_req(1));
		write_shift(32'd31);
		for (int i = 0; i < 20; i++) send_req(rand_req(1));
		write_shift(32'd0);
		for (int i = 0; i < 20; i++) send_req(rand_req(1));
		write_shift(32'd16);
		for (int i = 0; i < 60; i++) send_req(rand_req(1));
		write_shift(32'd12);
		for (int i = 0; i < 30; i++) send_req(rand_req(1));

		// saturate one page count, then come back down a little
		r = rand_req(0);
		r.addr = 64'h7_0000_1234;
		r.len = 16'd1;
		r.refd = '0;
		r.op = 1'b0;
		for (int i = 0; i < 258; i++) send_req(r);
		r.op = 1'b1;
		for (int i = 0; i < 3; i++) send_req(r);

		// fill the table past its slots so the sticky flag sets
		wait_drained();
		for (int i = 0; i < 5; i++) begin
			r.op = 1'b0;
			r.addr = 64'h40_0000_0FFF + 64'h10_0000 * i;
			r.len = 16'hFFFF;
			r.refd = '0;
			send_req(r);
		end
		for (int i = 0; i < 2; i++) begin
			r.op = 1'b1;
			r.addr = 64'h40_0000_0FFF;
			send_req(r);
		end
		for (int i = 0; i < 20; i++) send_req(rand_req(1));

		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_beats.size() == 0)
			$display("page_lock_refcount_table_top_tb: PASS");
		else
			$display("page_lock_refcount_table_top_tb: FAIL");
		$finish;
	end
endmodule
